/* src/tsrm_pkg.sv */
`default_nettype none

package tsrm_pkg;

    localparam int DEF_NUM_EQUITIES = 16;
    localparam int DEF_NUM_CLIENTS  = 64;
    localparam int DEF_HEAP_CAP     = 512;

    localparam int EQUITY_W   = 4;
    localparam int CLIENT_W   = 6;
    localparam int QTY_W      = 16;
    localparam int PRICE_W    = 16;
    localparam int SHARE_W    = 48;
    localparam int MONEY_W    = 64;
    localparam int TRADE_W    = 32;
    localparam int AMOUNT_W   = 32;

    // Reciprocal of one hundred for a 32-bit dividend: floor(x / 100) = (x * M) >> 37.
    localparam int            DIV100_SHIFT = 37;
    localparam logic [62:0]   DIV100_MAGIC = 63'd1374389535;
    localparam int            QUOT_W       = 26;

    typedef struct packed {
        logic clr_step;
        logic in_ready;
        logic load_in;
        logic acc;
        logic buy;
        logic srd;
        logic sell;
        logic top_rd;
        logic plan;
        logic push_chk;
        logic push_cmp;
        logic rep_chk;
        logic rep_l;
        logic rep_r;
        logic rep_dec;
        logic next_op;
        logic med_rd;
        logic med;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic drop;
        logic first;
        logic is_replace;
        logic at_root;
        logic push_up;
        logic leaf;
        logic has_r;
        logic stay;
        logic pend;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/tsrm_ifs.sv */
`default_nettype none

interface trade_if;
    logic                               valid;
    logic                               ready;
    logic [tsrm_pkg::EQUITY_W-1:0]      equity;
    logic [tsrm_pkg::CLIENT_W-1:0]      buyer_id;
    logic [tsrm_pkg::CLIENT_W-1:0]      seller_id;
    logic [tsrm_pkg::QTY_W-1:0]         quantity;
    logic [tsrm_pkg::PRICE_W-1:0]       price;

    modport source (output valid, equity, buyer_id, seller_id, quantity, price, input ready);
    modport sink   (input valid, equity, buyer_id, seller_id, quantity, price, output ready);
endinterface

interface result_if;
    logic                               valid;
    logic                               ready;
    logic [tsrm_pkg::PRICE_W-1:0]       mid_price;
    logic                               median_dropped;
    logic [tsrm_pkg::SHARE_W-1:0]       buyer_bought;
    logic signed [tsrm_pkg::MONEY_W-1:0] buyer_net;
    logic [tsrm_pkg::SHARE_W-1:0]       seller_sold;
    logic signed [tsrm_pkg::MONEY_W-1:0] seller_net;
    logic [tsrm_pkg::MONEY_W-1:0]       commission_total;
    logic [tsrm_pkg::MONEY_W-1:0]       money_total;
    logic [tsrm_pkg::TRADE_W-1:0]       trade_total;
    logic [tsrm_pkg::SHARE_W-1:0]       share_total;

    modport source (output valid, mid_price, median_dropped, buyer_bought, buyer_net,
                    seller_sold, seller_net, commission_total, money_total, trade_total,
                    share_total, input ready);
    modport sink   (input valid, mid_price, median_dropped, buyer_bought, buyer_net,
                    seller_sold, seller_net, commission_total, money_total, trade_total,
                    share_total, output ready);
endinterface

`default_nettype wire

/* src/tsrm_ctrl.sv */
`default_nettype none

module tsrm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              trade_valid,
    input  wire tsrm_pkg::status_t status,
    output tsrm_pkg::cmd_t         cmd
);

    typedef enum logic [17:0] {
        S_CLR      = 18'b000000000000000001,
        S_IDLE     = 18'b000000000000000010,
        S_ACC      = 18'b000000000000000100,
        S_BUY      = 18'b000000000000001000,
        S_SRD      = 18'b000000000000010000,
        S_SELL     = 18'b000000000000100000,
        S_TOP_RD   = 18'b000000000001000000,
        S_TOP      = 18'b000000000010000000,
        S_PUSH_CHK = 18'b000000000100000000,
        S_PUSH_CMP = 18'b000000001000000000,
        S_REP_CHK  = 18'b000000010000000000,
        S_REP_L    = 18'b000000100000000000,
        S_REP_R    = 18'b000001000000000000,
        S_REP_DEC  = 18'b000010000000000000,
        S_NEXT     = 18'b000100000000000000,
        S_MED_RD   = 18'b001000000000000000,
        S_MED      = 18'b010000000000000000,
        S_FIN      = 18'b100000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (trade_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_BUY;
            end
            S_BUY:
            begin
                cmd.buy    = 1'b1;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.srd    = 1'b1;
                state_next = S_SELL;
            end
            S_SELL:
            begin
                cmd.sell   = 1'b1;
                state_next = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                cmd.top_rd = 1'b1;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                cmd.plan = 1'b1;
                if (status.drop || status.first)
                begin
                    state_next = S_FIN;
                end
                else if (status.is_replace)
                begin
                    state_next = S_REP_CHK;
                end
                else
                begin
                    state_next = S_PUSH_CHK;
                end
            end
            S_PUSH_CHK:
            begin
                cmd.push_chk = 1'b1;
                state_next   = status.at_root ? S_NEXT : S_PUSH_CMP;
            end
            S_PUSH_CMP:
            begin
                cmd.push_cmp = 1'b1;
                state_next   = status.push_up ? S_PUSH_CHK : S_NEXT;
            end
            S_REP_CHK:
            begin
                cmd.rep_chk = 1'b1;
                state_next  = status.leaf ? S_NEXT : S_REP_L;
            end
            S_REP_L:
            begin
                cmd.rep_l  = 1'b1;
                state_next = status.has_r ? S_REP_R : S_REP_DEC;
            end
            S_REP_R:
            begin
                cmd.rep_r  = 1'b1;
                state_next = S_REP_DEC;
            end
            S_REP_DEC:
            begin
                cmd.rep_dec = 1'b1;
                state_next  = status.stay ? S_NEXT : S_REP_CHK;
            end
            S_NEXT:
            begin
                cmd.next_op = 1'b1;
                state_next  = status.pend ? S_PUSH_CHK : S_MED_RD;
            end
            S_MED_RD:
            begin
                cmd.med_rd = 1'b1;
                state_next = S_MED;
            end
            S_MED:
            begin
                cmd.med    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/tsrm_dp.sv */
`default_nettype none

module tsrm_dp #(
    parameter int NUM_EQUITIES = tsrm_pkg::DEF_NUM_EQUITIES,
    parameter int NUM_CLIENTS  = tsrm_pkg::DEF_NUM_CLIENTS,
    parameter int HEAP_CAP     = tsrm_pkg::DEF_HEAP_CAP
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tsrm_pkg::cmd_t                    cmd,
    output tsrm_pkg::status_t                      status,
    input  wire logic [tsrm_pkg::EQUITY_W-1:0]     in_equity,
    input  wire logic [tsrm_pkg::CLIENT_W-1:0]     in_buyer_id,
    input  wire logic [tsrm_pkg::CLIENT_W-1:0]     in_seller_id,
    input  wire logic [tsrm_pkg::QTY_W-1:0]        in_quantity,
    input  wire logic [tsrm_pkg::PRICE_W-1:0]      in_price,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [tsrm_pkg::PRICE_W-1:0]           out_mid_price,
    output logic                                   out_median_dropped,
    output logic [tsrm_pkg::SHARE_W-1:0]           out_buyer_bought,
    output logic signed [tsrm_pkg::MONEY_W-1:0]    out_buyer_net,
    output logic [tsrm_pkg::SHARE_W-1:0]           out_seller_sold,
    output logic signed [tsrm_pkg::MONEY_W-1:0]    out_seller_net,
    output logic [tsrm_pkg::MONEY_W-1:0]           out_commission_total,
    output logic [tsrm_pkg::MONEY_W-1:0]           out_money_total,
    output logic [tsrm_pkg::TRADE_W-1:0]           out_trade_total,
    output logic [tsrm_pkg::SHARE_W-1:0]           out_share_total
);

    localparam int EW    = (NUM_EQUITIES > 1) ? $clog2(NUM_EQUITIES) : 1;
    localparam int CLW   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int MAXD  = (NUM_CLIENTS > NUM_EQUITIES) ? NUM_CLIENTS : NUM_EQUITIES;
    localparam int SW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int IDXW  = $clog2(HEAP_CAP);
    localparam int SZW   = $clog2(HEAP_CAP + 1);
    localparam int CNTW  = $clog2(2 * HEAP_CAP + 1);
    localparam int DEPTH = NUM_EQUITIES * HEAP_CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = tsrm_pkg::PRICE_W;
    localparam int QW    = tsrm_pkg::QTY_W;
    localparam int SHW   = tsrm_pkg::SHARE_W;
    localparam int MW    = tsrm_pkg::MONEY_W;
    localparam int CLDW  = 2 * SHW + MW;
    localparam int EQDW  = CNTW + PW;
    localparam int NEQIN = 1 << tsrm_pkg::EQUITY_W;
    localparam int NCLIN = 1 << tsrm_pkg::CLIENT_W;

    function automatic logic ranks_above(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                         input logic is_max);
        ranks_above = is_max ? (a > b) : (a < b);
    endfunction

    logic [EW-1:0]  eq_map [NEQIN];
    logic [CLW-1:0] cl_map [NCLIN];

    always_comb
    begin
        for (int k = 0; k < NEQIN; k++)
        begin
            eq_map[k] = EW'(k % NUM_EQUITIES);
        end
        for (int k = 0; k < NCLIN; k++)
        begin
            cl_map[k] = CLW'(k % NUM_CLIENTS);
        end
    end

    logic [CLDW-1:0] cl_mem [NUM_CLIENTS];
    logic [EQDW-1:0] eq_mem [NUM_EQUITIES];
    logic [PW-1:0]   lo_mem [DEPTH];
    logic [PW-1:0]   hi_mem [DEPTH];

    logic [CLDW-1:0] cl_rd_reg;
    logic [EQDW-1:0] eq_rd_reg;
    logic [PW-1:0]   lo_rd_reg;
    logic [PW-1:0]   hi_rd_reg;

    logic [SW-1:0]   clr_reg;
    logic [EW-1:0]   e_reg;
    logic [CLW-1:0]  b_reg;
    logic [CLW-1:0]  s_reg;
    logic [QW-1:0]   q_reg;
    logic [PW-1:0]   p_reg;
    logic [tsrm_pkg::AMOUNT_W-1:0] amount_reg;
    logic [tsrm_pkg::QUOT_W-1:0]   quot_reg;
    logic [AW-1:0]   base_reg;
    logic [CNTW-1:0] n_reg;
    logic [PW-1:0]   med_old_reg;
    logic [PW-1:0]   med_out_reg;
    logic            dropped_reg;
    logic [SHW-1:0]  bb_reg;
    logic [MW-1:0]   bn_reg;
    logic [SHW-1:0]  ss_reg;
    logic [MW-1:0]   sn_reg;
    logic [MW-1:0]   comm_reg;
    logic [MW-1:0]   money_reg;
    logic [tsrm_pkg::TRADE_W-1:0] trade_reg;
    logic [SHW-1:0]  share_reg;
    logic            op_max_reg;
    logic [SZW-1:0]  size_reg;
    logic [IDXW-1:0] idx_reg;
    logic [PW-1:0]   val_reg;
    logic [PW-1:0]   best_val_reg;
    logic [IDXW-1:0] best_idx_reg;
    logic            best_stay_reg;
    logic            pend_reg;
    logic            pend_max_reg;
    logic [SZW-1:0]  pend_size_reg;
    logic [PW-1:0]   pend_val_reg;
    logic            out_valid_reg;

    logic [PW-1:0]   cur_rd;
    logic [IDXW-1:0] parent;
    logic [IDXW+1:0] left_idx;
    logic [IDXW+1:0] right_idx;
    logic [AW-1:0]   cur_addr;
    logic [SZW-1:0]  half_lo;
    logic [SZW-1:0]  half_up;
    logic [62:0]     div_prod;
    logic [SHW-1:0]  buy_bought;
    logic [MW-1:0]   buy_net;
    logic [SHW-1:0]  sell_sold;
    logic [MW-1:0]   sell_net;
    logic [PW:0]     mean_sum;
    logic [PW-1:0]   med_new;

    logic            hp_ren;
    logic [AW-1:0]   hp_raddr;
    logic            we_lo;
    logic            we_hi;
    logic [AW-1:0]   hp_waddr;
    logic [PW-1:0]   hp_wdata;
    logic            cl_ren;
    logic [CLW-1:0]  cl_raddr;
    logic            cl_we;
    logic [CLW-1:0]  cl_waddr;
    logic [CLDW-1:0] cl_wdata;
    logic            eq_we;
    logic [EW-1:0]   eq_waddr;
    logic [EQDW-1:0] eq_wdata;

    assign cur_rd    = op_max_reg ? lo_rd_reg : hi_rd_reg;
    assign parent    = (idx_reg - IDXW'(1)) >> 1;
    assign left_idx  = {1'b0, idx_reg, 1'b1};
    assign right_idx = {1'b0, idx_reg, 1'b0} + (IDXW+2)'(2);
    assign cur_addr  = base_reg + AW'(idx_reg);
    assign half_lo   = SZW'(n_reg >> 1);
    assign half_up   = SZW'(({1'b0, n_reg} + (CNTW+1)'(1)) >> 1);
    assign div_prod  = 63'(amount_reg) * tsrm_pkg::DIV100_MAGIC;
    assign buy_bought = cl_rd_reg[CLDW-1 -: SHW] + SHW'(q_reg);
    assign buy_net    = cl_rd_reg[MW-1:0] - MW'(amount_reg);
    assign sell_sold  = cl_rd_reg[MW +: SHW] + SHW'(q_reg);
    assign sell_net   = cl_rd_reg[MW-1:0] + MW'(amount_reg);
    assign mean_sum   = {1'b0, lo_rd_reg} + {1'b0, hi_rd_reg};
    assign med_new    = n_reg[0] ? mean_sum[PW:1] : lo_rd_reg;

    always_comb
    begin
        status.clr_done   = (clr_reg == SW'(MAXD - 1));
        status.drop       = (n_reg >= CNTW'(2 * HEAP_CAP));
        status.first      = (n_reg == '0);
        status.is_replace = n_reg[0] ? (p_reg < lo_rd_reg) : (p_reg > hi_rd_reg);
        status.at_root    = (idx_reg == '0);
        status.push_up    = ranks_above(val_reg, cur_rd, op_max_reg);
        status.leaf       = (left_idx >= (IDXW+2)'(size_reg));
        status.has_r      = (right_idx < (IDXW+2)'(size_reg));
        status.stay       = best_stay_reg;
        status.pend       = pend_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        hp_ren   = 1'b0;
        hp_raddr = base_reg;
        we_lo    = 1'b0;
        we_hi    = 1'b0;
        hp_waddr = cur_addr;
        hp_wdata = val_reg;
        cl_ren   = 1'b0;
        cl_raddr = b_reg;
        cl_we    = 1'b0;
        cl_waddr = b_reg;
        cl_wdata = {buy_bought, cl_rd_reg[MW +: SHW], buy_net};
        eq_we    = 1'b0;
        eq_waddr = e_reg;
        eq_wdata = {n_reg + CNTW'(1), med_new};

        if (cmd.clr_step)
        begin
            cl_we    = ({1'b0, clr_reg} < (SW+1)'(NUM_CLIENTS));
            cl_waddr = clr_reg[CLW-1:0];
            cl_wdata = '0;
            eq_we    = ({1'b0, clr_reg} < (SW+1)'(NUM_EQUITIES));
            eq_waddr = clr_reg[EW-1:0];
            eq_wdata = '0;
        end
        if (cmd.acc)
        begin
            cl_ren = 1'b1;
        end
        if (cmd.buy)
        begin
            cl_we = 1'b1;
        end
        if (cmd.srd)
        begin
            cl_ren   = 1'b1;
            cl_raddr = s_reg;
        end
        if (cmd.sell)
        begin
            cl_we    = 1'b1;
            cl_waddr = s_reg;
            cl_wdata = {cl_rd_reg[CLDW-1 -: SHW], sell_sold, sell_net};
        end
        if (cmd.top_rd || cmd.med_rd)
        begin
            hp_ren = 1'b1;
        end
        if (cmd.plan && status.first && !status.drop)
        begin
            we_lo    = 1'b1;
            hp_waddr = base_reg;
            hp_wdata = p_reg;
            eq_we    = 1'b1;
            eq_wdata = {CNTW'(1), p_reg};
        end
        if (cmd.push_chk)
        begin
            if (status.at_root)
            begin
                we_lo = op_max_reg;
                we_hi = !op_max_reg;
            end
            else
            begin
                hp_ren   = 1'b1;
                hp_raddr = base_reg + AW'(parent);
            end
        end
        if (cmd.push_cmp)
        begin
            we_lo    = op_max_reg;
            we_hi    = !op_max_reg;
            hp_wdata = status.push_up ? cur_rd : val_reg;
        end
        if (cmd.rep_chk)
        begin
            if (status.leaf)
            begin
                we_lo = op_max_reg;
                we_hi = !op_max_reg;
            end
            else
            begin
                hp_ren   = 1'b1;
                hp_raddr = base_reg + AW'(left_idx[IDXW-1:0]);
            end
        end
        if (cmd.rep_l && status.has_r)
        begin
            hp_ren   = 1'b1;
            hp_raddr = base_reg + AW'(right_idx[IDXW-1:0]);
        end
        if (cmd.rep_dec)
        begin
            we_lo    = op_max_reg;
            we_hi    = !op_max_reg;
            hp_wdata = best_stay_reg ? val_reg : best_val_reg;
        end
        if (cmd.med)
        begin
            eq_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_lo)
        begin
            lo_mem[hp_waddr] <= hp_wdata;
        end
        if (we_hi)
        begin
            hi_mem[hp_waddr] <= hp_wdata;
        end
        if (hp_ren)
        begin
            lo_rd_reg <= lo_mem[hp_raddr];
            hi_rd_reg <= hi_mem[hp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        if (cl_ren)
        begin
            cl_rd_reg <= cl_mem[cl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eq_we)
        begin
            eq_mem[eq_waddr] <= eq_wdata;
        end
        if (cmd.acc)
        begin
            eq_rd_reg <= eq_mem[e_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            comm_reg      <= '0;
            money_reg     <= '0;
            trade_reg     <= '0;
            share_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step && !status.clr_done)
            begin
                clr_reg <= clr_reg + SW'(1);
            end
            if (cmd.srd)
            begin
                comm_reg  <= comm_reg + MW'({quot_reg, 1'b0});
                money_reg <= money_reg + MW'(amount_reg);
                trade_reg <= trade_reg + tsrm_pkg::TRADE_W'(1);
                share_reg <= share_reg + SHW'(q_reg);
            end
            if (cmd.plan)
            begin
                pend_reg <= !status.drop && !status.first && status.is_replace;
            end
            if (cmd.next_op)
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            e_reg       <= eq_map[in_equity];
            b_reg       <= cl_map[in_buyer_id];
            s_reg       <= cl_map[in_seller_id];
            q_reg       <= in_quantity;
            p_reg       <= in_price;
            dropped_reg <= 1'b0;
        end
        if (cmd.acc)
        begin
            amount_reg <= tsrm_pkg::AMOUNT_W'(q_reg) * tsrm_pkg::AMOUNT_W'(p_reg);
            base_reg   <= AW'(e_reg) * AW'(HEAP_CAP);
        end
        if (cmd.buy)
        begin
            quot_reg    <= div_prod[tsrm_pkg::DIV100_SHIFT +: tsrm_pkg::QUOT_W];
            n_reg       <= eq_rd_reg[EQDW-1 -: CNTW];
            med_old_reg <= eq_rd_reg[PW-1:0];
            bb_reg      <= buy_bought;
            bn_reg      <= buy_net;
        end
        if (cmd.sell)
        begin
            ss_reg <= sell_sold;
            sn_reg <= sell_net;
            if (s_reg == b_reg)
            begin
                bn_reg <= sell_net;
            end
        end
        if (cmd.plan)
        begin
            if (status.drop)
            begin
                dropped_reg <= 1'b1;
                med_out_reg <= med_old_reg;
            end
            else if (status.first)
            begin
                med_out_reg <= p_reg;
            end
            val_reg <= p_reg;
            if (!n_reg[0])
            begin
                op_max_reg    <= !status.is_replace;
                size_reg      <= half_lo;
                idx_reg       <= status.is_replace ? '0 : IDXW'(half_lo);
                pend_max_reg  <= 1'b1;
                pend_size_reg <= half_lo;
                pend_val_reg  <= hi_rd_reg;
            end
            else
            begin
                op_max_reg    <= status.is_replace;
                size_reg      <= status.is_replace ? half_up : half_lo;
                idx_reg       <= status.is_replace ? '0 : IDXW'(half_lo);
                pend_max_reg  <= 1'b0;
                pend_size_reg <= half_lo;
                pend_val_reg  <= lo_rd_reg;
            end
        end
        if (cmd.push_cmp && status.push_up)
        begin
            idx_reg <= parent;
        end
        if (cmd.rep_l)
        begin
            if (ranks_above(cur_rd, val_reg, op_max_reg))
            begin
                best_val_reg  <= cur_rd;
                best_idx_reg  <= left_idx[IDXW-1:0];
                best_stay_reg <= 1'b0;
            end
            else
            begin
                best_val_reg  <= val_reg;
                best_idx_reg  <= idx_reg;
                best_stay_reg <= 1'b1;
            end
        end
        if (cmd.rep_r && ranks_above(cur_rd, best_val_reg, op_max_reg))
        begin
            best_val_reg  <= cur_rd;
            best_idx_reg  <= right_idx[IDXW-1:0];
            best_stay_reg <= 1'b0;
        end
        if (cmd.rep_dec && !best_stay_reg)
        begin
            idx_reg <= best_idx_reg;
        end
        if (cmd.next_op && pend_reg)
        begin
            op_max_reg <= pend_max_reg;
            size_reg   <= pend_size_reg;
            idx_reg    <= IDXW'(pend_size_reg);
            val_reg    <= pend_val_reg;
        end
        if (cmd.med)
        begin
            med_out_reg <= med_new;
        end
        if (cmd.out_load)
        begin
            out_mid_price        <= med_out_reg;
            out_median_dropped   <= dropped_reg;
            out_buyer_bought     <= bb_reg;
            out_buyer_net        <= bn_reg;
            out_seller_sold      <= ss_reg;
            out_seller_net       <= sn_reg;
            out_commission_total <= comm_reg;
            out_money_total      <= money_reg;
            out_trade_total      <= trade_reg;
            out_share_total      <= share_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/trade_settlement_running_median.sv */
`default_nettype none

// Channel  Role     Handshake     Payload
// trade    sink     valid/ready   equity, buyer_id, seller_id, quantity, price
// result   source   valid/ready   median, drop flag, client tallies, running totals
//
// A trade steps through a tally read, buyer and seller updates, a heap top read and a plan,
// then the heap walk and a median update; a price that is the first of its equity or is
// dropped skips both. A replaced top is then pushed into the other heap. A push reads and
// compares a parent per level climbed and a top replacement reads the children and writes per
// level descended, as each heap memory has a single read port. After reset a clearing pass
// zeroes the client and equity tables, during which no trade transfer is taken.
// A new trade is taken while the previous result still waits in the output register.

module trade_settlement_running_median #(
    parameter int NUM_EQUITIES = tsrm_pkg::DEF_NUM_EQUITIES,
    parameter int NUM_CLIENTS  = tsrm_pkg::DEF_NUM_CLIENTS,
    parameter int HEAP_CAP     = tsrm_pkg::DEF_HEAP_CAP
) (
    input  wire logic clk,
    input  wire logic rst_n,
    trade_if.sink     trade,
    result_if.source  result
);

    tsrm_pkg::cmd_t    cmd;
    tsrm_pkg::status_t status;

    assign trade.ready = cmd.in_ready;

    tsrm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .trade_valid (trade.valid),
        .status      (status),
        .cmd         (cmd)
    );

    tsrm_dp #(
        .NUM_EQUITIES (NUM_EQUITIES),
        .NUM_CLIENTS  (NUM_CLIENTS),
        .HEAP_CAP     (HEAP_CAP)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_equity            (trade.equity),
        .in_buyer_id          (trade.buyer_id),
        .in_seller_id         (trade.seller_id),
        .in_quantity          (trade.quantity),
        .in_price             (trade.price),
        .out_ready            (result.ready),
        .out_valid            (result.valid),
        .out_mid_price        (result.mid_price),
        .out_median_dropped   (result.median_dropped),
        .out_buyer_bought     (result.buyer_bought),
        .out_buyer_net        (result.buyer_net),
        .out_seller_sold      (result.seller_sold),
        .out_seller_net       (result.seller_net),
        .out_commission_total (result.commission_total),
        .out_money_total      (result.money_total),
        .out_trade_total      (result.trade_total),
        .out_share_total      (result.share_total)
    );

endmodule

`default_nettype wire

/* dv/trade_settlement_running_median_tb.sv */
`timescale 1ns / 100ps

module trade_settlement_running_median_tb;

    localparam int EQUITY_W         = tsrm_pkg::EQUITY_W;
    localparam int CLIENT_W         = tsrm_pkg::CLIENT_W;
    localparam int QTY_W            = tsrm_pkg::QTY_W;
    localparam int PRICE_W          = tsrm_pkg::PRICE_W;
    localparam int SHARE_W          = tsrm_pkg::SHARE_W;
    localparam int MONEY_W          = tsrm_pkg::MONEY_W;
    localparam int TRADE_W          = tsrm_pkg::TRADE_W;
    localparam int DEF_NUM_EQUITIES = tsrm_pkg::DEF_NUM_EQUITIES;
    localparam int DEF_NUM_CLIENTS  = tsrm_pkg::DEF_NUM_CLIENTS;
    localparam int DEF_HEAP_CAP     = tsrm_pkg::DEF_HEAP_CAP;

    typedef struct packed {
        logic [PRICE_W-1:0] mid_price;
        logic               median_dropped;
        logic [SHARE_W-1:0] buyer_bought;
        logic [MONEY_W-1:0] buyer_net;
        logic [SHARE_W-1:0] seller_sold;
        logic [MONEY_W-1:0] seller_net;
        logic [MONEY_W-1:0] commission_total;
        logic [MONEY_W-1:0] money_total;
        logic [TRADE_W-1:0] trade_total;
        logic [SHARE_W-1:0] share_total;
    } settlement_t;

    localparam int LOWER_HEAP = 0;
    localparam int UPPER_HEAP = 1;
    localparam int PRICE_SLOTS = 2 * DEF_HEAP_CAP;

    class settlement_scoreboard;
        settlement_t        awaited_q[$];
        int                 errors = 0;
        logic [MONEY_W-1:0] commission_sum = '0;
        logic [MONEY_W-1:0] money_sum = '0;
        logic [TRADE_W-1:0] trade_count = '0;
        logic [SHARE_W-1:0] share_count = '0;
        logic [SHARE_W-1:0] bought[DEF_NUM_CLIENTS];
        logic [SHARE_W-1:0] sold[DEF_NUM_CLIENTS];
        logic [MONEY_W-1:0] net[DEF_NUM_CLIENTS];
        int unsigned        price_count[DEF_NUM_EQUITIES];
        logic [PRICE_W-1:0] median[DEF_NUM_EQUITIES];
        logic [PRICE_W-1:0] heaps[2][DEF_NUM_EQUITIES][DEF_HEAP_CAP];

        function new();
            foreach (bought[i])
            begin
                bought[i] = '0;
                sold[i] = '0;
                net[i] = '0;
            end
            foreach (price_count[i])
            begin
                price_count[i] = 0;
                median[i] = '0;
            end
        endfunction

        function bit outranks(int side, logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
            return (side == UPPER_HEAP) ? (a < b) : (a > b);
        endfunction

        function void heap_insert(int side, int e, int size, logic [PRICE_W-1:0] v);
            int                 i;
            int                 p;
            logic [PRICE_W-1:0] t;
            i = size;
            heaps[side][e][i] = v;
            while (i > 0)
            begin
                p = (i - 1) / 2;
                if (!outranks(side, heaps[side][e][i], heaps[side][e][p]))
                    break;
                t = heaps[side][e][i];
                heaps[side][e][i] = heaps[side][e][p];
                heaps[side][e][p] = t;
                i = p;
            end
        endfunction

        function void heap_replace_top(int side, int e, int size, logic [PRICE_W-1:0] v);
            int                 i;
            int                 l;
            int                 best;
            logic [PRICE_W-1:0] t;
            i = 0;
            heaps[side][e][0] = v;
            forever
            begin
                l = 2 * i + 1;
                best = i;
                if (l < size && outranks(side, heaps[side][e][l], heaps[side][e][best]))
                    best = l;
                if (l + 1 < size && outranks(side, heaps[side][e][l + 1], heaps[side][e][best]))
                    best = l + 1;
                if (best == i)
                    break;
                t = heaps[side][e][i];
                heaps[side][e][i] = heaps[side][e][best];
                heaps[side][e][best] = t;
                i = best;
            end
        endfunction

        function bit add_price(int e, logic [PRICE_W-1:0] p);
            int unsigned        n;
            logic [PRICE_W-1:0] t;
            logic [16:0]        total;
            n = price_count[e];
            if (n >= PRICE_SLOTS)
                return 1'b1;
            if (n == 0)
            begin
                heaps[LOWER_HEAP][e][0] = p;
                median[e] = p;
            end
            else if (n % 2 == 0)
            begin
                if (p <= heaps[UPPER_HEAP][e][0])
                    heap_insert(LOWER_HEAP, e, n / 2, p);
                else
                begin
                    t = heaps[UPPER_HEAP][e][0];
                    heap_replace_top(UPPER_HEAP, e, n / 2, p);
                    heap_insert(LOWER_HEAP, e, n / 2, t);
                end
                median[e] = heaps[LOWER_HEAP][e][0];
            end
            else
            begin
                if (p >= heaps[LOWER_HEAP][e][0])
                    heap_insert(UPPER_HEAP, e, n / 2, p);
                else
                begin
                    t = heaps[LOWER_HEAP][e][0];
                    heap_replace_top(LOWER_HEAP, e, (n + 1) / 2, p);
                    heap_insert(UPPER_HEAP, e, n / 2, t);
                end
                total = heaps[LOWER_HEAP][e][0] + heaps[UPPER_HEAP][e][0];
                median[e] = total[16:1];
            end
            price_count[e] = n + 1;
            return 1'b0;
        endfunction

        function void note_trade(int e, int b, int s, logic [QTY_W-1:0] q,
                                 logic [PRICE_W-1:0] p);
            logic [MONEY_W-1:0] amount;
            settlement_t        r;
            amount = {32'd0, q} * {48'd0, p};
            commission_sum += (amount / 100) * 2;
            money_sum += amount;
            share_count += q;
            trade_count += 1;
            r.median_dropped = add_price(e, p);
            bought[b] += q;
            net[b] -= amount;
            sold[s] += q;
            net[s] += amount;
            r.mid_price = median[e];
            r.buyer_bought = bought[b];
            r.buyer_net = net[b];
            r.seller_sold = sold[s];
            r.seller_net = net[s];
            r.commission_total = commission_sum;
            r.money_total = money_sum;
            r.trade_total = trade_count;
            r.share_total = share_count;
            awaited_q.push_back(r);
        endfunction

        function void compare(string field, logic [MONEY_W-1:0] exp, logic [MONEY_W-1:0] act);
            if (exp !== act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
            end
        endfunction

        function void check_result(settlement_t got);
            settlement_t exp;
            if (awaited_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer %h", $time, got);
                return;
            end
            exp = awaited_q.pop_front();
            compare("mid_price", exp.mid_price, got.mid_price);
            compare("median_dropped", exp.median_dropped, got.median_dropped);
            compare("buyer_bought", exp.buyer_bought, got.buyer_bought);
            compare("buyer_net", exp.buyer_net, got.buyer_net);
            compare("seller_sold", exp.seller_sold, got.seller_sold);
            compare("seller_net", exp.seller_net, got.seller_net);
            compare("commission_total", exp.commission_total, got.commission_total);
            compare("money_total", exp.money_total, got.money_total);
            compare("trade_total", exp.trade_total, got.trade_total);
            compare("share_total", exp.share_total, got.share_total);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    trade_if  trade ();
    result_if result ();

    settlement_scoreboard sb = new();
    bit      calm_tail = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;

    trade_settlement_running_median i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .trade  (trade),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && trade.valid && trade.ready)
            sb.note_trade(trade.equity, trade.buyer_id, trade.seller_id,
                          trade.quantity, trade.price);
        if (rst_n && result.valid && result.ready)
        begin
            sb.check_result({result.mid_price, result.median_dropped,
                             result.buyer_bought, result.buyer_net, result.seller_sold,
                             result.seller_net, result.commission_total,
                             result.money_total, result.trade_total, result.share_total});
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((trade.valid && trade.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        bit held_off;
        held_off = 0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && results_seen >= 300)
            begin
                held_off = 1;
                result.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 2) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    task automatic send_trade(int e, int b, int s, int q, int p);
        trade.valid <= 1'b1;
        trade.equity <= EQUITY_W'(e);
        trade.buyer_id <= CLIENT_W'(b);
        trade.seller_id <= CLIENT_W'(s);
        trade.quantity <= QTY_W'(q);
        trade.price <= PRICE_W'(p);
        do
            @(posedge clk);
        while (!trade.ready);
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            trade.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(95, 105);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    initial
    begin
        int b;
        rst_n = 1'b0;
        trade.valid = 1'b0;
        trade.equity = '0;
        trade.buyer_id = '0;
        trade.seller_id = '0;
        trade.quantity = '0;
        trade.price = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_trade(0, 0, 63, 0, 0);
        send_trade(0, 63, 0, 16'hFFFF, 16'hFFFF);
        send_trade(0, 5, 5, 16'hFFFF, 16'hFFFF);
        send_trade(0, 5, 5, 100, 1);
        send_trade(15, 63, 63, 1, 16'hFFFF);
        send_trade(15, 1, 2, 99, 16'hFFFE);
        send_trade(15, 2, 1, 3, 0);
        send_trade(15, 1, 2, 7, 16'hFFFF);
        send_trade(15, 3, 4, 7, 16'h8000);
        send_trade(3, 10, 20, 50, 200);
        send_trade(3, 20, 10, 50, 100);
        send_trade(3, 10, 20, 50, 300);
        send_trade(3, 10, 20, 50, 200);
        send_trade(3, 10, 20, 50, 50);
        send_trade(3, 10, 20, 50, 400);
        send_trade(8, 42, 21, 16'h5555, 16'hAAAA);
        send_trade(7, 21, 42, 16'hAAAA, 16'h5555);

        // Many trades into one equity build both heaps several levels deep.
        for (int i = 0; i < 480; i++)
            send_trade(9, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 16'hFFFF),
                       (i % 5 == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(1000, 1063));

        for (int i = 0; i < 300; i++)
        begin
            if (i == 200)
                calm_tail = 1;
            b = $urandom_range(0, 63);
            send_trade($urandom_range(0, 15), b,
                       ($urandom_range(0, 9) == 0) ? b : $urandom_range(0, 63),
                       pick_value(), pick_value());
        end
        trade.valid <= 1'b0;

        while (sb.awaited_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
